/* sv/rss_pkg.sv */
// Shared types and constants for the running series statistics core.
// Used by rss_ctrl, rss_dp and the top level; depends on nothing.
package rss_pkg;

	localparam int COUNT_W = 32;
	localparam int STAMP_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 32'hFFFF_FFFE;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic mean_add;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

/* sv/rss_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Stand-alone; used by rss_dp for the mean update.
module rss_div #(
	parameter int DW = 49
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic [DW-1:0] quotient,
	output logic          busy
);
	localparam int CNT_W = $clog2(DW + 1);

	logic [31:0]      rem_q;
	logic [31:0]      dvs_q;
	logic [DW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [32:0]      shifted;
	logic [32:0]      trial;

	assign shifted  = {rem_q, quo_q[DW-1]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign quotient = quo_q;
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

endmodule

/* sv/rss_dp.sv */
// Datapath: input capture, statistics registers, mean update and output register.
// Depends on rss_pkg and rss_div.
module rss_dp #(
	parameter int SAMPLE_BITS = 32,
	localparam int IN_W  = ((SAMPLE_BITS + 32 + 7) / 8) * 8,
	localparam int OUT_W = ((7 * SAMPLE_BITS + 65 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rss_pkg::cmd_t    cmd,
	output rss_pkg::status_t st,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);
	import rss_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int GB    = (SB <= 46) ? 16 : (62 - SB);
	localparam int ACC_W = SB + GB;
	localparam int DW    = ACC_W + 1;

	logic               kind_q;
	logic               inv_q;
	logic signed [SB-1:0] x_q;
	logic [STAMP_W-1:0] time_q;

	logic [COUNT_W-1:0]   count_q;
	logic [ACC_W-1:0]     mean_q;
	logic signed [SB-1:0] max_q;
	logic signed [SB-1:0] min_q;
	logic [SB-1:0]        first_q;
	logic [SB-1:0]        latest_q;
	logic [STAMP_W-1:0]   first_stamp_q;
	logic [STAMP_W-1:0]   latest_stamp_q;
	logic                 neg_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic          take;
	logic [DW-1:0] scaled;
	logic [DW-1:0] diff;
	logic [DW-1:0] mag;
	logic [DW-1:0] quo;
	logic [DW-1:0] quo_signed;
	logic          div_busy;
	logic          has;
	logic [SB:0]   mid_sum;
	logic [OUT_W-1:0] out_d;

	assign take   = !kind_q && !inv_q && (count_q < COUNT_LIMIT);
	assign scaled = {x_q[SB-1], x_q, {GB{1'b0}}};
	assign diff   = scaled - {mean_q[ACC_W-1], mean_q};
	assign mag    = diff[DW-1] ? (~diff + DW'(1)) : diff;
	assign quo_signed = neg_q ? (~quo + DW'(1)) : quo;

	assign st.need_div = take && (count_q != '0);
	assign st.div_busy = div_busy;
	assign st.out_free = !out_valid_q || m_tready;

	rss_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.update && st.need_div),
		.dividend (mag),
		.divisor  (count_q + 32'd1),
		.quotient (quo),
		.busy     (div_busy)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= s_tuser[0];
			inv_q  <= s_tuser[1];
			x_q    <= s_tdata[SB-1:0];
			time_q <= s_tdata[SB+31:SB];
		end
		if (cmd.update) begin
			neg_q <= diff[DW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			mean_q         <= '0;
			max_q          <= '0;
			min_q          <= '0;
			first_q        <= '0;
			latest_q       <= '0;
			first_stamp_q  <= '0;
			latest_stamp_q <= '0;
		end else if (cmd.update) begin
			if (kind_q) begin
				count_q        <= '0;
				mean_q         <= '0;
				max_q          <= '0;
				min_q          <= '0;
				first_q        <= '0;
				latest_q       <= '0;
				first_stamp_q  <= time_q;
				latest_stamp_q <= time_q;
			end else if (take) begin
				count_q        <= count_q + 32'd1;
				latest_q       <= x_q;
				latest_stamp_q <= time_q;
				if (count_q == '0) begin
					first_q       <= x_q;
					max_q         <= x_q;
					min_q         <= x_q;
					mean_q        <= scaled[ACC_W-1:0];
					first_stamp_q <= time_q;
				end else begin
					if (x_q > max_q) begin
						max_q <= x_q;
					end
					if (x_q < min_q) begin
						min_q <= x_q;
					end
				end
			end
		end else if (cmd.mean_add) begin
			mean_q <= mean_q + quo_signed[ACC_W-1:0];
		end
	end

	assign has     = count_q != '0;
	assign mid_sum = {max_q[SB-1], max_q} + {min_q[SB-1], min_q};

	always_comb begin
		logic [SB-1:0] mean_f, max_f, min_f, first_f, latest_f, spread_f, mid_f;
		mean_f   = has ? mean_q[ACC_W-1:GB] : '0;
		max_f    = has ? max_q : '0;
		min_f    = has ? min_q : '0;
		first_f  = has ? first_q : '0;
		latest_f = has ? latest_q : '0;
		spread_f = has ? (max_q - min_q) : '0;
		mid_f    = has ? mid_sum[SB:1] : '0;
		out_d = OUT_W'({has, mid_f, spread_f, latest_stamp_q - first_stamp_q, count_q,
			latest_f, first_f, min_f, max_f, mean_f});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= out_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* sv/rss_ctrl.sv */
// Controller state machine: sequences capture, update, divide and result load.
// Depends on rss_pkg.
module rss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rss_pkg::status_t st,
	output rss_pkg::cmd_t    cmd
);
	import rss_pkg::*;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.update = 1'b1;
				state_d    = st.need_div ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (!st.div_busy) begin
					cmd.mean_add = 1'b1;
					state_d      = ST_OUT;
				end
			end
			ST_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/running_series_statistics_core.sv */
// Running series statistics core: count, mean, min, max, first/latest sample and stamps.
// Each request is captured, then evaluated; restarts, ignored and first samples go straight
// to the result register, and other samples first wait for the divider and the mean add.
// A new request is taken only after the last result has been loaded; result stalls delay it.
// Reset: arst_n clears all statistics, stamps, controller and output valid at once.
// Depends on rss_pkg, rss_ctrl, rss_dp.
module running_series_statistics_core #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// sample_value, time_ms, zero padding
	input  logic [((SAMPLE_BITS + 32 + 7) / 8) * 8 - 1:0] s_tdata,
	// kind, sample_invalid
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// mean, maximum, minimum, first_sample, latest_sample, sample_count,
	// duration_ms, spread, midpoint, has_data, zero padding
	output logic [((7 * SAMPLE_BITS + 65 + 7) / 8) * 8 - 1:0] m_tdata
);
	import rss_pkg::*;

	cmd_t    cmd;
	status_t st;

	rss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rss_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_ready_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !st.div_busy)
		else $error("request taken while divider busy");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken during processing");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> st.out_free)
		else $error("result loaded over pending result");

endmodule
